/* sv/bfsa_pkg.sv */
// Shared types and constants for the breath flow swing alarm.
// Holds the transaction payload structs, status/event codes and flow widths.
// No dependencies.
package bfsa_pkg;

   localparam int FLOW_WIDTH = 16;
   localparam int THR_WIDTH  = 16;
   // Swing is peak minus trough without wrap; wide enough for the threshold too.
   localparam int SWING_WIDTH = ((FLOW_WIDTH + 1 > THR_WIDTH) ? FLOW_WIDTH + 1 : THR_WIDTH) + 1;

   localparam logic signed [FLOW_WIDTH-1:0] PEAK_REARM   = FLOW_WIDTH'(-2000);
   localparam logic signed [FLOW_WIDTH-1:0] TROUGH_REARM = FLOW_WIDTH'(2000);
   localparam logic [THR_WIDTH-1:0]         THR_RESET    = THR_WIDTH'(100);

   // Alarm status encoding
   localparam logic [2:0] ST_FALSE     = 3'd0;
   localparam logic [2:0] ST_DETECTED  = 3'd1;
   localparam logic [2:0] ST_TRUE      = 3'd2;
   localparam logic [2:0] ST_DISPLAYED = 3'd3;
   localparam logic [2:0] ST_CANCELED  = 3'd4;
   localparam logic [2:0] ST_INVALID   = 3'd5;

   // Event log codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_START = 2'd1;
   localparam logic [1:0] EV_END   = 2'd2;

   typedef struct packed {
      logic signed [FLOW_WIDTH-1:0] flow_sample;
      logic [2:0]                   alarm_status;
      logic [2:0]                   overheat_status;
      logic [2:0]                   speed_fault_status;
      logic [2:0]                   disconnect_status;
      logic                         second_cycle;
      logic                         in_exhalation;
   } req_type;

   typedef struct packed {
      logic       status_write;
      logic [2:0] new_status;
      logic [1:0] event_code;
      logic       priority_set;
      logic       priority_clear;
      logic       bad_status;
   } rsp_type;

   typedef struct packed {
      logic signed [SWING_WIDTH-1:0] swing;
      logic                          exh_ended;
   } track_type;

endpackage

/* sv/bfsa_tracker.sv */
// Running peak/trough flow tracker with end-of-exhalation re-arm.
// Depends on bfsa_pkg.
module bfsa_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic signed [bfsa_pkg::FLOW_WIDTH-1:0] flow_sample,
   input  logic                                   in_exhalation,
   output bfsa_pkg::track_type                    track
);
   import bfsa_pkg::*;

   logic signed [FLOW_WIDTH-1:0] peak_ff, peak_in;
   logic signed [FLOW_WIDTH-1:0] trough_ff, trough_in;
   logic                         was_exhaling_ff;
   logic signed [FLOW_WIDTH-1:0] peak_upd, trough_upd;
   logic                         exh_ended;

   always_comb begin
      peak_upd   = (flow_sample > peak_ff)   ? flow_sample : peak_ff;
      trough_upd = (flow_sample < trough_ff) ? flow_sample : trough_ff;
      exh_ended  = !in_exhalation && was_exhaling_ff;
      track.swing     = SWING_WIDTH'(peak_upd) - SWING_WIDTH'(trough_upd);
      track.exh_ended = exh_ended;
      // re-arm comes after this transaction's decision
      peak_in   = exh_ended ? PEAK_REARM   : peak_upd;
      trough_in = exh_ended ? TROUGH_REARM : trough_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff         <= PEAK_REARM;
         trough_ff       <= TROUGH_REARM;
         was_exhaling_ff <= 1'b0;
      end else if (advance) begin
         peak_ff         <= peak_in;
         trough_ff       <= trough_in;
         was_exhaling_ff <= in_exhalation;
      end
   end

endmodule

/* sv/bfsa_decide.sv */
// Alarm status decision: raise from false, clear from displayed, flag errors.
// Depends on bfsa_pkg.
module bfsa_decide (
   input  bfsa_pkg::req_type                   req,
   input  bfsa_pkg::track_type                 track,
   input  logic [bfsa_pkg::THR_WIDTH-1:0]      threshold,
   output bfsa_pkg::rsp_type                   rsp
);
   import bfsa_pkg::*;

   logic signed [SWING_WIDTH-1:0] thr_s;
   logic                          no_fault;
   logic                          fault_true;

   always_comb begin
      thr_s      = $signed(SWING_WIDTH'(threshold));
      no_fault   = (req.overheat_status == ST_FALSE) &&
                   (req.speed_fault_status == ST_FALSE) &&
                   (req.disconnect_status == ST_FALSE);
      fault_true = (req.overheat_status == ST_TRUE) ||
                   (req.speed_fault_status == ST_TRUE) ||
                   (req.disconnect_status == ST_TRUE);

      rsp.status_write   = 1'b0;
      rsp.new_status     = ST_FALSE;
      rsp.event_code     = EV_NONE;
      rsp.priority_set   = 1'b0;
      rsp.priority_clear = 1'b0;
      rsp.bad_status     = 1'b0;

      case (req.alarm_status)
         ST_FALSE: begin
            if ((track.swing < thr_s) && no_fault && req.second_cycle && track.exh_ended) begin
               rsp.status_write = 1'b1;
               rsp.new_status   = ST_TRUE;
               rsp.event_code   = EV_START;
               rsp.priority_set = 1'b1;
            end
         end
         ST_TRUE: begin
         end
         ST_DISPLAYED: begin
            if ((track.swing > thr_s) || fault_true) begin
               rsp.status_write   = 1'b1;
               rsp.new_status     = ST_FALSE;
               rsp.event_code     = EV_END;
               rsp.priority_clear = 1'b1;
            end
         end
         default: begin
            // detected, canceled, invalid and unused codes
            rsp.bad_status = 1'b1;
         end
      endcase
   end

endmodule

/* sv/breath_flow_swing_alarm.sv */
// Top level of the breath flow swing alarm: input register, tracker, decision,
// result register and the threshold CSR. Depends on bfsa_pkg, bfsa_tracker, bfsa_decide.
//
// One transaction per monitoring tick; one result per transaction. A new
// transaction is accepted every cycle unless the output stalls: the input
// register hands its item to the result register while the peak/trough state
// updates in the same edge, so the sustained rate is one item per clock and
// rsp_valid rises once the item is loaded into the result register. Throughput
// drops only while rsp_ready is held low and both registers are full. The threshold
// resets to 100 and must be written only while no transaction is in flight.
module breath_flow_swing_alarm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bfsa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bfsa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [bfsa_pkg::THR_WIDTH-1:0]    csr_wr_data
);
   import bfsa_pkg::*;

   logic                 in_valid_ff;
   req_type              in_data_ff;
   logic                 out_valid_ff;
   rsp_type              out_data_ff, out_data_in;
   logic [THR_WIDTH-1:0] threshold_ff;
   logic                 advance;
   track_type            track;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   bfsa_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .flow_sample   (in_data_ff.flow_sample),
      .in_exhalation (in_data_ff.in_exhalation),
      .track         (track)
   );

   bfsa_decide u_decide (
      .req       (in_data_ff),
      .track     (track),
      .threshold (threshold_ff),
      .rsp       (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= THR_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

/* sv/bfsa_checker.sv */
// Port-level checker for breath_flow_swing_alarm, attached by bind.
// Depends on bfsa_pkg.
module bfsa_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bfsa_pkg::rsp_type rsp_data
);
   import bfsa_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_write_strobes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status_write |->
         (rsp_data.priority_set != rsp_data.priority_clear) &&
         ((rsp_data.event_code == EV_START && rsp_data.new_status == ST_TRUE &&
           rsp_data.priority_set) ||
          (rsp_data.event_code == EV_END && rsp_data.new_status == ST_FALSE &&
           rsp_data.priority_clear)))
      else $error("status write with inconsistent event or strobes");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.status_write |->
         rsp_data.new_status == ST_FALSE && rsp_data.event_code == EV_NONE &&
         !rsp_data.priority_set && !rsp_data.priority_clear)
      else $error("side outputs active without status write");

   a_error_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_status |-> !rsp_data.status_write)
      else $error("status write together with bad status");

endmodule

bind breath_flow_swing_alarm bfsa_checker u_bfsa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/breath_flow_swing_alarm_checker.sv */
// Checker for the breath flow swing alarm: tracks peak/trough flow and the threshold,
// predicts each tick's alarm action and compares it with the rsp channel.
// Depends on bfsa_pkg.
module breath_flow_swing_alarm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bfsa_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bfsa_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [bfsa_pkg::THR_WIDTH-1:0] csr_wr_data,
   output int                             fail_count,
   output int                             actions_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bfsa_pkg::*;

   logic signed [FLOW_WIDTH-1:0] flow_peak;
   logic signed [FLOW_WIDTH-1:0] flow_trough;
   logic                         exhaling_q;
   logic [THR_WIDTH-1:0]         swing_thr;
   rsp_type                      alarm_actions_q[$];

   function automatic rsp_type predict_alarm_action(req_type t);
      rsp_type a;
      logic    exh_ended;
      logic    no_fault;
      logic    fault_true;
      int      swing;
      int      thr;
      a          = '0;
      exh_ended  = !t.in_exhalation && exhaling_q;
      no_fault   = (t.overheat_status == ST_FALSE) && (t.speed_fault_status == ST_FALSE) &&
                   (t.disconnect_status == ST_FALSE);
      fault_true = (t.overheat_status == ST_TRUE) || (t.speed_fault_status == ST_TRUE) ||
                   (t.disconnect_status == ST_TRUE);
      if (t.flow_sample > flow_peak)
         flow_peak = t.flow_sample;
      if (t.flow_sample < flow_trough)
         flow_trough = t.flow_sample;
      swing = int'(flow_peak) - int'(flow_trough);
      thr   = int'(swing_thr);
      case (t.alarm_status)
         ST_FALSE: begin
            if (swing < thr && no_fault && t.second_cycle && exh_ended) begin
               a.status_write = 1'b1;
               a.new_status   = ST_TRUE;
               a.event_code   = EV_START;
               a.priority_set = 1'b1;
            end
         end
         ST_TRUE: ;
         ST_DISPLAYED: begin
            if (swing > thr || fault_true) begin
               a.status_write   = 1'b1;
               a.new_status     = ST_FALSE;
               a.event_code     = EV_END;
               a.priority_clear = 1'b1;
            end
         end
         default: a.bad_status = 1'b1;
      endcase
      // extremes re-arm after the decision, whatever the status
      if (exh_ended) begin
         flow_peak   = PEAK_REARM;
         flow_trough = TROUGH_REARM;
      end
      exhaling_q = t.in_exhalation;
      return a;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         flow_peak   = PEAK_REARM;
         flow_trough = TROUGH_REARM;
         exhaling_q  = 1'b0;
         swing_thr   = THR_RESET;
         fail_count  = 0;
         alarm_actions_q.delete();
      end else begin
         if (csr_wr_en)
            swing_thr = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (alarm_actions_q.size() == 0) begin
               $error("result transaction with nothing expected: %p", got);
               fail_count++;
            end else begin
               want = alarm_actions_q.pop_front();
               if (got.status_write !== want.status_write) begin
                  $error("status_write: expected %0d, got %0d",
                         want.status_write, got.status_write);
                  fail_count++;
               end
               if (got.new_status !== want.new_status) begin
                  $error("new_status: expected %0d, got %0d", want.new_status, got.new_status);
                  fail_count++;
               end
               if (got.event_code !== want.event_code) begin
                  $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
                  fail_count++;
               end
               if (got.priority_set !== want.priority_set) begin
                  $error("priority_set: expected %0d, got %0d",
                         want.priority_set, got.priority_set);
                  fail_count++;
               end
               if (got.priority_clear !== want.priority_clear) begin
                  $error("priority_clear: expected %0d, got %0d",
                         want.priority_clear, got.priority_clear);
                  fail_count++;
               end
               if (got.bad_status !== want.bad_status) begin
                  $error("bad_status: expected %0d, got %0d",
                         want.bad_status, got.bad_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            alarm_actions_q.push_back(predict_alarm_action(req_data));
      end
      actions_pending = alarm_actions_q.size();
   end

endmodule

/* tb/breath_flow_swing_alarm_test.sv */
// Testbench top for the breath flow swing alarm: clock, reset, tick stimulus,
// rsp backpressure and threshold writes. Depends on bfsa_pkg, the block and its checker.
module breath_flow_swing_alarm_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bfsa_pkg::*;

   localparam int HOLD_CYCLES = 300;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [THR_WIDTH-1:0] csr_wr_data = '0;
   int                   fail_count;
   int                   actions_pending;

   int idle_pct  = 0;
   int stall_pct = 0;
   bit hold_off  = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   breath_flow_swing_alarm DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   breath_flow_swing_alarm_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .actions_pending (actions_pending)
   );

   // Receiver: random stalls, or one long hold-off when asked
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type tick(int flow, logic [2:0] st, logic [2:0] ovh,
                                    logic [2:0] spd, logic [2:0] dis, logic sec, logic exh);
      req_type t;
      t.flow_sample        = FLOW_WIDTH'(flow);
      t.alarm_status       = st;
      t.overheat_status    = ovh;
      t.speed_fault_status = spd;
      t.disconnect_status  = dis;
      t.second_cycle       = sec;
      t.in_exhalation      = exh;
      return t;
   endfunction

   function automatic logic [2:0] pick_status();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return ST_FALSE;
      else if (r < 75)
         return ST_DISPLAYED;
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic logic [2:0] pick_fault();
      if ($urandom_range(0, 2) == 0)
         return ST_TRUE;
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic req_type breath_tick(int center, int span, logic exh);
      req_type t;
      int      flow;
      case ($urandom_range(0, 9))
         0:       flow = int'($signed(16'($urandom())));
         1:       flow = $urandom_range(0, 1) ? 32767 : -32768;
         default: flow = center + $urandom_range(0, span) - span / 2;
      endcase
      t = tick(flow, pick_status(), ST_FALSE, ST_FALSE, ST_FALSE,
               $urandom_range(0, 99) < 85, exh);
      if ($urandom_range(0, 3) == 0) begin
         t.overheat_status    = pick_fault();
         t.speed_fault_status = pick_fault();
         t.disconnect_status  = pick_fault();
      end
      return t;
   endfunction

   // Entered and left at a falling edge; valid stays up between back-to-back ticks
   task automatic send_tick(req_type t);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (actions_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(logic [THR_WIDTH-1:0] thr);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Inhalation ticks then exhalation ticks, so exhalation ends on the next breath
   task automatic run_breaths(int n_ticks);
      int sent;
      int center;
      int span;
      int n_insp;
      int n_exh;
      sent = 0;
      while (sent < n_ticks) begin
         center = $urandom_range(0, 2000) - 1000;
         span   = $urandom_range(10, 600);
         n_insp = $urandom_range(1, 6);
         n_exh  = $urandom_range(1, 4);
         for (int i = 0; i < n_insp + n_exh; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_tick(req_type'($bits(req_type)'($urandom())));
            else
               send_tick(breath_tick(center, span, i >= n_insp));
            sent++;
         end
      end
   endtask

   initial begin
      logic [THR_WIDTH-1:0] seg_thr[8];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed ticks at the reset threshold of 100
      send_tick(tick(32767, ST_DISPLAYED, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(-32768, ST_DISPLAYED, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, ST_TRUE, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1));
      send_tick(tick(0, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(10, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b1));
      send_tick(tick(20, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, ST_DETECTED, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, ST_CANCELED, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, ST_INVALID, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, 3'd6, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, 3'd7, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, ST_DISPLAYED, ST_TRUE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, ST_DISPLAYED, ST_FALSE, ST_TRUE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(0, ST_DISPLAYED, ST_FALSE, ST_FALSE, ST_TRUE, 1'b1, 1'b0));
      send_tick(tick(0, ST_DISPLAYED, ST_DETECTED, ST_CANCELED, ST_INVALID, 1'b1, 1'b0));
      // swing exactly at threshold: neither clear nor raise
      send_tick(tick(100, ST_DISPLAYED, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b1));
      send_tick(tick(50, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      // raise blocked by a non-true fault, then by a clear second_cycle flag
      send_tick(tick(5, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b1));
      send_tick(tick(5, ST_FALSE, ST_DETECTED, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      send_tick(tick(5, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b1));
      send_tick(tick(5, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b0, 1'b0));
      send_tick(tick(5, ST_FALSE, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b1));
      send_tick(tick(5, ST_DISPLAYED, ST_FALSE, ST_FALSE, ST_FALSE, 1'b1, 1'b0));
      wait_idle();

      seg_thr = '{16'd0, 16'd300, 16'hFFFF, 16'd150, 16'($urandom()), 16'd40, 16'd1000,
                  THR_RESET};
      for (int seg = 0; seg < 8; seg++) begin
         case (seg / 2)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase
         write_threshold(seg_thr[seg]);
         run_breaths(85);
         wait_idle();
      end

      // long receiver hold-off while ticks keep coming, so the input backs up
      idle_pct  = 0;
      stall_pct = 0;
      write_threshold(16'd200);
      hold_off = 1'b1;
      run_breaths(40);
      wait_idle();

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
